// ----- rtl/srf_pkg.sv -----
package srf_pkg;

    localparam int INDEX_BITS    = 24;
    localparam int SYMBOL_BITS   = 8;
    localparam int LCP_BITS      = 24;
    localparam int BWT_BITS      = 8;
    localparam int FIELD_BITS    = 24;
    localparam int SYMBOL_COUNT  = 2 ** SYMBOL_BITS;
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 72;

    typedef enum logic [1:0] {
        OP_PRIME = 2'd0,
        OP_RISE  = 2'd1,
        OP_EQUAL = 2'd2,
        OP_DROP  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic                   last;
        logic [LCP_BITS-1:0]    lcp;
        logic [SYMBOL_BITS-1:0] sym;
        logic [SYMBOL_BITS-1:0] prev_sym;
        logic [INDEX_BITS-1:0]  pos;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [FIELD_BITS-1:0] to_field(input logic [INDEX_BITS-1:0] pos);
        logic [FIELD_BITS+INDEX_BITS-1:0] wide;
        wide = {{FIELD_BITS{1'b0}}, pos};
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

// ----- rtl/supermaximal_repeat_finder.sv -----
// Results are registered in the output register after their items pass the queue.
// Throughput: one item per cycle unless the output stalls; classifier, two-entry queue
// and interval unit keep that rate; an output stall stalls the queue and the input.
// Reset (i_rst_n low at a clock edge, synchronous) empties the queue and output register,
// sets the position to zero and clears all plateau state; no clearing pass follows.
module supermaximal_repeat_finder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // lcp_value [23:0], bwt_symbol [31:24]
    input  logic [srf_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // interval_start [23:0], interval_end [47:24], repeat_length [71:48]
    output logic [srf_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata
);
    import srf_pkg::*;

    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;
    logic   push;
    logic   pop;

    srf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_qstat (qstat),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    srf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    srf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.empty |-> !pop)
        else $error("queue read while empty");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_DATA_BITS-1 -: LCP_BITS] != '0))
        else $error("result with zero repeat length");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (qstat.empty && !o_m_axis_tvalid))
        else $error("queue or output not empty after reset");

endmodule

// ----- rtl/srf_front.sv -----
module srf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [srf_pkg::IN_DATA_BITS-1:0] i_data,
    input  logic                      i_last,
    input  srf_pkg::t_qstat           i_qstat,
    output logic                      o_ready,
    output logic                      o_push,
    output srf_pkg::t_cmd             o_cmd
);
    import srf_pkg::*;

    logic [INDEX_BITS-1:0]  r_pos;
    logic [LCP_BITS-1:0]    r_prev_lcp;
    logic [SYMBOL_BITS-1:0] r_prev_sym;
    logic                   r_primed;

    logic [LCP_BITS-1:0]    lcp;
    logic [SYMBOL_BITS-1:0] sym;

    assign lcp     = i_data[LCP_BITS-1:0];
    assign sym     = i_data[LCP_BITS +: SYMBOL_BITS];
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.last     = i_last;
        o_cmd.lcp      = lcp;
        o_cmd.sym      = sym;
        o_cmd.prev_sym = r_prev_sym;
        o_cmd.pos      = r_pos;
        if (!r_primed) begin
            o_cmd.op = OP_PRIME;
        end else if (lcp > r_prev_lcp) begin
            o_cmd.op = OP_RISE;
        end else if (lcp == r_prev_lcp) begin
            o_cmd.op = OP_EQUAL;
        end else begin
            o_cmd.op = OP_DROP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_prev_lcp <= '0;
            r_prev_sym <= '0;
            r_primed   <= 1'b0;
        end else if (o_push) begin
            if (i_last) begin
                // The array ends here: the next item opens a new one at position zero.
                r_pos      <= '0;
                r_prev_lcp <= '0;
                r_prev_sym <= '0;
                r_primed   <= 1'b0;
            end else begin
                r_pos      <= r_pos + INDEX_BITS'(1);
                r_prev_lcp <= lcp;
                r_prev_sym <= sym;
                r_primed   <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/srf_queue.sv -----
module srf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  srf_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output srf_pkg::t_cmd   o_cmd,
    output srf_pkg::t_qstat o_qstat
);
    import srf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_cmd         = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == 2'd2);
    assign o_qstat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/srf_back.sv -----
module srf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srf_pkg::t_cmd                     i_cmd,
    input  srf_pkg::t_qstat                   i_qstat,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [srf_pkg::OUT_DATA_BITS-1:0] o_data
);
    import srf_pkg::*;

    logic                    r_in_plateau, n_in_plateau;
    logic [INDEX_BITS-1:0]   r_start,      n_start;
    logic [LCP_BITS-1:0]     r_len,        n_len;
    logic [SYMBOL_COUNT-1:0] r_seen,       n_seen;
    logic                    r_distinct,   n_distinct;

    logic                    r_out_valid;
    logic [FIELD_BITS-1:0]   r_out_start;
    logic [FIELD_BITS-1:0]   r_out_end;
    logic [LCP_BITS-1:0]     r_out_len;

    logic                    emit;
    logic [INDEX_BITS-1:0]   emit_start;
    logic [INDEX_BITS-1:0]   emit_end;
    logic [LCP_BITS-1:0]     emit_len;
    logic [INDEX_BITS-1:0]   pos_prev;
    logic [SYMBOL_COUNT-1:0] sym_bit;
    logic [SYMBOL_COUNT-1:0] prev_bit;

    assign o_pop    = !i_qstat.empty && (!r_out_valid || i_ready);
    assign pos_prev = i_cmd.pos - INDEX_BITS'(1);
    assign sym_bit  = {{(SYMBOL_COUNT-1){1'b0}}, 1'b1} << i_cmd.sym;
    assign prev_bit = {{(SYMBOL_COUNT-1){1'b0}}, 1'b1} << i_cmd.prev_sym;

    always_comb begin
        n_in_plateau = r_in_plateau;
        n_start      = r_start;
        n_len        = r_len;
        n_seen       = r_seen;
        n_distinct   = r_distinct;
        emit         = 1'b0;
        emit_end     = pos_prev;

        case (i_cmd.op)
            OP_PRIME: begin
                n_in_plateau = r_in_plateau;
            end
            OP_RISE: begin
                // A rise restarts the candidate one position back.
                n_in_plateau = 1'b1;
                n_start      = pos_prev;
                n_len        = i_cmd.lcp;
                n_seen       = sym_bit | prev_bit;
                n_distinct   = (i_cmd.sym != i_cmd.prev_sym);
            end
            OP_EQUAL: begin
                if (r_in_plateau) begin
                    if (r_seen[i_cmd.sym]) begin
                        n_distinct = 1'b0;
                    end
                    n_seen = r_seen | sym_bit;
                end
            end
            OP_DROP: begin
                if (r_in_plateau) begin
                    emit         = r_distinct;
                    n_in_plateau = 1'b0;
                end
            end
            default: begin
                n_in_plateau = r_in_plateau;
            end
        endcase

        // A rise on the last item opens a candidate that the end closes at once.
        emit_start = n_start;
        emit_len   = n_len;

        if (i_cmd.last) begin
            // The end of the array closes a plateau that is still open.
            if (n_in_plateau && n_distinct && !emit) begin
                emit     = 1'b1;
                emit_end = i_cmd.pos;
            end
            n_in_plateau = 1'b0;
            n_start      = '0;
            n_len        = '0;
            n_seen       = '0;
            n_distinct   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_plateau <= 1'b0;
            r_start      <= '0;
            r_len        <= '0;
            r_seen       <= '0;
            r_distinct   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_plateau <= n_in_plateau;
                r_start      <= n_start;
                r_len        <= n_len;
                r_seen       <= n_seen;
                r_distinct   <= n_distinct;
                r_out_valid  <= emit;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_start <= to_field(emit_start);
            r_out_end   <= to_field(emit_end);
            r_out_len   <= emit_len;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {r_out_len, r_out_end, r_out_start};

endmodule

// ----- tb/tb_supermaximal_repeat_finder.sv -----
`timescale 1ns / 1ps

module tb_supermaximal_repeat_finder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1350;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [23:0] rep_len;
        logic [23:0] stop_pos;
        logic [23:0] start_pos;
    } t_repeat;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [srf_pkg::IN_DATA_BITS-1:0]  s_data = '0;
    logic                              s_last = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [srf_pkg::OUT_DATA_BITS-1:0] m_data;

    // Software copy of the plateau tracker.
    logic [23:0]  sa_pos;
    logic [23:0]  prev_lcp;
    logic [7:0]   prev_sym;
    logic         in_plateau;
    logic [23:0]  cand_start;
    logic [23:0]  plateau_lcp;
    logic [255:0] seen_syms;
    logic         syms_distinct;
    logic         primed;

    t_repeat pending_repeats[$];
    int      error_count = 0;
    int      items_sent = 0;
    int      arrays_sent = 0;
    int      repeats_seen = 0;
    int      cycle_count = 0;
    logic    no_gaps = 1'b0;

    supermaximal_repeat_finder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 6);
    end

    task automatic clear_tracker();
        sa_pos        = '0;
        prev_lcp      = '0;
        prev_sym      = '0;
        in_plateau    = 1'b0;
        cand_start    = '0;
        plateau_lcp   = '0;
        seen_syms     = '0;
        syms_distinct = 1'b1;
        primed        = 1'b0;
    endtask

    task automatic note_symbol(input logic [7:0] sym);
        if (seen_syms[sym])
            syms_distinct = 1'b0;
        else
            seen_syms[sym] = 1'b1;
    endtask

    task automatic push_repeat(input logic [23:0] stop);
        t_repeat r;
        r.start_pos = cand_start;
        r.stop_pos  = stop;
        r.rep_len   = plateau_lcp;
        pending_repeats.push_back(r);
    endtask

    // Advances the tracker by one position and queues the repeat it closes, if any.
    task automatic track_position(input logic [23:0] lcp, input logic [7:0] sym,
                                  input logic last);
        logic closed;
        closed = 1'b0;
        if (!primed) begin
            primed = 1'b1;
        end else if (lcp > prev_lcp) begin
            in_plateau    = 1'b1;
            cand_start    = sa_pos - 24'd1;
            plateau_lcp   = lcp;
            seen_syms     = '0;
            syms_distinct = 1'b1;
            note_symbol(prev_sym);
            note_symbol(sym);
        end else if (lcp == prev_lcp) begin
            if (in_plateau)
                note_symbol(sym);
        end else if (in_plateau) begin
            if (syms_distinct) begin
                push_repeat(sa_pos - 24'd1);
                closed = 1'b1;
            end
            in_plateau = 1'b0;
        end
        prev_lcp = lcp;
        prev_sym = sym;
        if (last) begin
            // The end of the array acts as a zero LCP and closes an open plateau.
            if (in_plateau && syms_distinct && !closed)
                push_repeat(sa_pos);
            clear_tracker();
        end else begin
            sa_pos = sa_pos + 24'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_repeat got;
        t_repeat want;
        if (i_rst_n && m_valid && m_ready) begin
            got = m_data;
            repeats_seen++;
            if (pending_repeats.size() == 0) begin
                $display("unexpected repeat at cycle %0d: start %0d end %0d length %0d",
                         cycle_count, got.start_pos, got.stop_pos, got.rep_len);
                error_count++;
            end else begin
                want = pending_repeats.pop_front();
                if (got.start_pos !== want.start_pos)
                    report_mismatch("interval start", got.start_pos, want.start_pos);
                if (got.stop_pos !== want.stop_pos)
                    report_mismatch("interval end", got.stop_pos, want.stop_pos);
                if (got.rep_len !== want.rep_len)
                    report_mismatch("repeat length", got.rep_len, want.rep_len);
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for a following item.
    task automatic send_item(input logic [23:0] lcp, input logic [7:0] sym,
                             input logic last);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 6) begin
                s_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= {sym, lcp};
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        track_position(lcp, sym, last);
        items_sent++;
        if (last)
            arrays_sent++;
        @(negedge i_clk);
    endtask

    task automatic test_single_position();
        send_item(24'd7, 8'h41, 1'b1);
    endtask

    task automatic test_distinct_plateau();
        send_item(24'd0, 8'h10, 1'b0);
        send_item(24'd3, 8'h11, 1'b0);
        send_item(24'd3, 8'h12, 1'b0);
        send_item(24'd3, 8'h13, 1'b0);
        send_item(24'd0, 8'h14, 1'b1);
    endtask

    task automatic test_repeated_symbol();
        send_item(24'd1, 8'h20, 1'b0);
        send_item(24'd5, 8'h21, 1'b0);
        send_item(24'd5, 8'h20, 1'b0);
        send_item(24'd2, 8'h22, 1'b1);
    endtask

    // A second rise restarts the candidate one position before the rising item.
    task automatic test_rise_restart();
        send_item(24'd0, 8'h30, 1'b0);
        send_item(24'd2, 8'h31, 1'b0);
        send_item(24'd2, 8'h32, 1'b0);
        send_item(24'd5, 8'h33, 1'b0);
        send_item(24'd5, 8'h34, 1'b0);
        send_item(24'd1, 8'h35, 1'b1);
    endtask

    task automatic test_close_at_end();
        send_item(24'd0, 8'h00, 1'b0);
        send_item(24'd4, 8'h01, 1'b0);
        send_item(24'd4, 8'h02, 1'b1);
    endtask

    // Field extremes, with the drop landing on the last position.
    task automatic test_drop_on_last();
        send_item(24'd0, 8'h00, 1'b0);
        send_item(24'hFFFFFF, 8'hFF, 1'b0);
        send_item(24'hFFFFFF, 8'hAA, 1'b0);
        send_item(24'd1, 8'h55, 1'b1);
    endtask

    function automatic logic [7:0] pick_symbol(input int style);
        if (style == 0)
            return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly small LCP walks that form plateaus; some arrays sit at large LCP values
    // and some are pure noise.
    task automatic send_random_array();
        int          len;
        int          kind;
        int          sym_style;
        logic [23:0] base;
        logic [23:0] lcp;
        logic [7:0]  sym;
        len  = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 24);
        kind = $urandom_range(0, 9);
        sym_style = $urandom_range(0, 1);
        base = (kind == 8) ? 24'($urandom_range(0, 24'hFFFFFF)) : 24'd0;
        if (base > 24'hFFFFF0)
            base = 24'hFFFFF0;
        for (int i = 0; i < len; i++) begin
            if (kind == 9)
                lcp = 24'($urandom);
            else
                lcp = base + 24'($urandom_range(0, 4));
            sym = pick_symbol(sym_style);
            send_item(lcp, sym, i == len - 1);
        end
    endtask

    task automatic test_random_arrays();
        while (items_sent < ITEM_TARGET) begin
            no_gaps = (items_sent >= 400 && items_sent < 700);
            send_random_array();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        clear_tracker();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_single_position();
        test_distinct_plateau();
        test_repeated_symbol();
        test_rise_restart();
        test_close_at_end();
        test_drop_on_last();
        test_random_arrays();

        s_valid <= 1'b0;
        while (pending_repeats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d positions in %0d suffix arrays, checked %0d repeat intervals",
                 items_sent, arrays_sent, repeats_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/srf_pkg.sv
rtl/srf_front.sv
rtl/srf_queue.sv
rtl/srf_back.sv
rtl/supermaximal_repeat_finder.sv
tb/tb_supermaximal_repeat_finder.sv
